>>> hw/rtl/sacd_pkg.sv
// Shared constants and types for the set-associative cache tag directory.
package sacd_pkg;

	// Cache geometry
	localparam int WAYS        = 4;
	localparam int SET_BITS    = 7;
	localparam int OFFSET_BITS = 6;

	localparam int ADDR_BITS  = 32;
	localparam int NUM_SETS   = 1 << SET_BITS;
	localparam int TAG_SHIFT  = OFFSET_BITS + SET_BITS;
	localparam int TAG_BITS   = ADDR_BITS - TAG_SHIFT;
	localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_BITS   = WAYS * (TAG_BITS + 1);
	localparam int LINE_BITS  = 9;
	localparam int COST_BITS  = 32;
	localparam int LFSR_BITS  = 16;

	// Cost and replacement constants
	localparam logic [COST_BITS-1:0] READ_HIT_COST = 32'd2;
	localparam logic [COST_BITS-1:0] MISS_COST     = 32'd200;
	localparam logic [LFSR_BITS-1:0] LFSR_TAPS     = 16'hB400;
	localparam logic [LFSR_BITS-1:0] LFSR_SEED     = 16'h0001;

	// Access kinds
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic update;
	} sacd_cmd_t;

endpackage

>>> hw/rtl/sacd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/sacd_ctrl.sv
// Controller state machine: accepts a transaction and sequences lookup and update.
module sacd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output sacd_pkg::sacd_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_LOOKUP = 2'b10
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = start && (state_q == ST_IDLE);
	assign cmd.update  = (state_q == ST_LOOKUP);

	// Checks
	a_capture_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.update) else $error("capture not followed by update");
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> busy) else $error("update while not busy");
	a_no_double_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> !cmd.update) else $error("update held two cycles");

endmodule

>>> hw/rtl/sacd_dpath.sv
// Datapath: set row RAM, row valid flags, tag compare, fill choice, LFSR and cost total.
module sacd_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sacd_pkg::sacd_cmd_t                   cmd,
	input  logic [sacd_pkg::ADDR_BITS-1:0]        address,
	input  logic                                  action,
	output logic                                  done,
	output logic                                  hit,
	output logic [sacd_pkg::LINE_BITS-1:0]        line_index,
	output logic [sacd_pkg::COST_BITS-1:0]        cycle_total
);

	localparam int WB = sacd_pkg::WAY_BITS;
	localparam int TB = sacd_pkg::TAG_BITS;
	localparam int SB = sacd_pkg::SET_BITS;

	// Captured transaction
	logic [SB-1:0] set_q;
	logic [TB-1:0] tag_q;
	logic          action_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q    <= address[sacd_pkg::TAG_SHIFT-1:sacd_pkg::OFFSET_BITS];
			tag_q    <= address[sacd_pkg::ADDR_BITS-1:sacd_pkg::TAG_SHIFT];
			action_q <= action;
		end
	end

	// Set row storage: per-way valid flags above per-way tags
	logic                          ram_we;
	logic [sacd_pkg::ROW_BITS-1:0] row_rd, row_wr;

	sacd_ram #(
		.WIDTH(sacd_pkg::ROW_BITS),
		.DEPTH(sacd_pkg::NUM_SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(set_q),
		.wdata(row_wr),
		.re   (cmd.capture),
		.raddr(address[sacd_pkg::TAG_SHIFT-1:sacd_pkg::OFFSET_BITS]),
		.rdata(row_rd)
	);

	// A row never written since reset reads as all ways invalid
	logic [sacd_pkg::NUM_SETS-1:0]  row_vld_q;
	logic [sacd_pkg::LFSR_BITS-1:0] victim_lfsr_q;
	logic [sacd_pkg::COST_BITS-1:0] cost_q;

	// Lookup and fill choice
	logic [TB-1:0]              way_tag [sacd_pkg::WAYS];
	logic [sacd_pkg::WAYS-1:0]  way_vld;
	logic                       hit_c, free_c;
	logic [WB-1:0]              hit_way, free_way, fill_way, use_way;
	logic [31:0]                line_wide;

	always_comb begin
		for (int w = 0; w < sacd_pkg::WAYS; w++) begin
			way_tag[w] = row_rd[w*TB +: TB];
			way_vld[w] = row_rd[sacd_pkg::WAYS*TB + w] && row_vld_q[set_q];
		end
		hit_c    = 1'b0;
		free_c   = 1'b0;
		hit_way  = '0;
		free_way = '0;
		// Scan from the top so the lowest way wins
		for (int w = sacd_pkg::WAYS - 1; w >= 0; w--) begin
			if (way_vld[w] && (way_tag[w] == tag_q)) begin
				hit_c   = 1'b1;
				hit_way = WB'(w);
			end
			if (!way_vld[w]) begin
				free_c   = 1'b1;
				free_way = WB'(w);
			end
		end
		// Way count is a power of two: the victim is the low LFSR bits
		fill_way = free_c ? free_way
			: WB'(victim_lfsr_q % sacd_pkg::LFSR_BITS'(sacd_pkg::WAYS));
		use_way  = hit_c ? hit_way : fill_way;
		line_wide = 32'(set_q) * 32'(sacd_pkg::WAYS) + 32'(use_way);
	end

	// Row write-back on a miss
	always_comb begin
		row_wr = row_rd;
		for (int w = 0; w < sacd_pkg::WAYS; w++) begin
			row_wr[sacd_pkg::WAYS*TB + w] = way_vld[w];
			if (WB'(w) == fill_way) begin
				row_wr[w*TB +: TB]             = tag_q;
				row_wr[sacd_pkg::WAYS*TB + w] = 1'b1;
			end
		end
	end

	assign ram_we = cmd.update && !hit_c;

	// Control state: row flags, LFSR, cost total, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q     <= '0;
			victim_lfsr_q <= sacd_pkg::LFSR_SEED;
			cost_q        <= '0;
			done          <= 1'b0;
		end else begin
			done <= cmd.update;
			if (cmd.update) begin
				if (hit_c) begin
					if (action_q == sacd_pkg::ACT_READ) cost_q <= cost_q + sacd_pkg::READ_HIT_COST;
				end else begin
					cost_q           <= cost_q + sacd_pkg::MISS_COST;
					row_vld_q[set_q] <= 1'b1;
					if (!free_c) begin
						victim_lfsr_q <= victim_lfsr_q[0]
							? ((victim_lfsr_q >> 1) ^ sacd_pkg::LFSR_TAPS)
							: (victim_lfsr_q >> 1);
					end
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit        <= hit_c;
			line_index <= line_wide[sacd_pkg::LINE_BITS-1:0];
		end
	end

	assign cycle_total = cost_q;

	// Checks
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		victim_lfsr_q != '0) else $error("victim LFSR reached zero");
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.update)) else $error("result strobe without update");
	a_miss_cost: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> cost_q == $past(cost_q) + sacd_pkg::MISS_COST)
		else $error("miss did not add miss cost");
	a_write_hit_cost: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit && (action_q == sacd_pkg::ACT_WRITE) |-> cost_q == $past(cost_q))
		else $error("write hit changed cost total");

endmodule

>>> hw/rtl/set_assoc_cache_tag_directory_top.sv
// Top level of the set-associative cache tag directory.
//
//  channel   ports                              handshake
//  access    address, action                    start high while busy low
//  result    hit, line_index, cycle_total       done high for one cycle
//
// An access reads the set row from the row RAM in the accept cycle, compares and
// writes it back in the next; the result shows in the cycle after that, in the same
// cycle a new access may be accepted. No new access is accepted while the previous
// one is in its lookup state with busy high.
// Reset clears the per-row valid flags, the cost total and seeds the LFSR; no
// clearing pass over the RAM is needed. The receiver cannot stall results.
module set_assoc_cache_tag_directory_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sacd_pkg::ADDR_BITS-1:0] address,
	input  logic                           action,
	output logic                           done,
	output logic                           hit,
	output logic [sacd_pkg::LINE_BITS-1:0] line_index,
	output logic [sacd_pkg::COST_BITS-1:0] cycle_total
);

	sacd_pkg::sacd_cmd_t cmd;

	sacd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	sacd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.address    (address),
		.action     (action),
		.done       (done),
		.hit        (hit),
		.line_index (line_index),
		.cycle_total(cycle_total)
	);

endmodule

>>> test/tb_set_assoc_cache_tag_directory_top.sv
// Self-checking testbench for the set-associative cache tag directory top level.
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_directory_top;

	localparam int NUM_LINES = sacd_pkg::NUM_SETS * sacd_pkg::WAYS;
	localparam int MAX_SHOWN = 10;

	// One lookup outcome as the block reports it
	typedef struct packed {
		logic                           hit;
		logic [sacd_pkg::LINE_BITS-1:0] line;
		logic [sacd_pkg::COST_BITS-1:0] total;
	} lookup_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [sacd_pkg::ADDR_BITS-1:0] address;
	logic                           action;
	logic                           done;
	logic                           hit;
	logic [sacd_pkg::LINE_BITS-1:0] line_index;
	logic [sacd_pkg::COST_BITS-1:0] cycle_total;

	// Shadow directory state
	bit                             line_valid [NUM_LINES];
	logic [sacd_pkg::TAG_BITS-1:0]  line_tag   [NUM_LINES];
	logic [sacd_pkg::LFSR_BITS-1:0] victim_seq;
	logic [sacd_pkg::COST_BITS-1:0] cost_total;

	lookup_result_t       pending_lookups[$];
	int                   error_count;
	int                   send_gap_pct;

	set_assoc_cache_tag_directory_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.address     (address),
		.action      (action),
		.done        (done),
		.hit         (hit),
		.line_index  (line_index),
		.cycle_total (cycle_total)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Builds an address from its tag, set and offset parts
	function automatic logic [sacd_pkg::ADDR_BITS-1:0] make_addr(
			input logic [sacd_pkg::TAG_BITS-1:0] tag,
			input int unsigned set_num, input int unsigned offset);
		logic [sacd_pkg::SET_BITS-1:0]    set_part;
		logic [sacd_pkg::OFFSET_BITS-1:0] off_part;
		set_part = set_num[sacd_pkg::SET_BITS-1:0];
		off_part = offset[sacd_pkg::OFFSET_BITS-1:0];
		return {tag, set_part, off_part};
	endfunction

	// Directory update for one access; queues the expected outcome
	function void predict_lookup(input logic [sacd_pkg::ADDR_BITS-1:0] addr, input logic act);
		int unsigned                   set_num;
		int unsigned                   base;
		int unsigned                   way;
		int unsigned                   line;
		logic [sacd_pkg::TAG_BITS-1:0] tag;
		bit                            matched;
		bit                            free_found;
		lookup_result_t                res;
		set_num    = 32'(addr[sacd_pkg::OFFSET_BITS +: sacd_pkg::SET_BITS]);
		tag        = addr[sacd_pkg::ADDR_BITS-1:sacd_pkg::TAG_SHIFT];
		base       = set_num * sacd_pkg::WAYS;
		matched    = 1'b0;
		free_found = 1'b0;
		line       = 0;
		for (way = 0; way < sacd_pkg::WAYS; way++) begin
			if (!matched && line_valid[base + way] && line_tag[base + way] == tag) begin
				matched = 1'b1;
				line    = base + way;
			end
		end
		if (matched) begin
			if (act == sacd_pkg::ACT_READ)
				cost_total = cost_total + sacd_pkg::READ_HIT_COST;
		end else begin
			// first invalid way, else LFSR victim
			for (way = 0; way < sacd_pkg::WAYS; way++) begin
				if (!free_found && !line_valid[base + way]) begin
					free_found = 1'b1;
					line       = base + way;
				end
			end
			if (!free_found) begin
				line = base + (victim_seq % sacd_pkg::WAYS);
				if (victim_seq[0])
					victim_seq = (victim_seq >> 1) ^ sacd_pkg::LFSR_TAPS;
				else
					victim_seq = victim_seq >> 1;
			end
			line_valid[line] = 1'b1;
			line_tag[line]   = tag;
			cost_total       = cost_total + sacd_pkg::MISS_COST;
		end
		res.hit   = matched;
		res.line  = line[sacd_pkg::LINE_BITS-1:0];
		res.total = cost_total;
		pending_lookups.push_back(res);
	endfunction

	// Issues one access transaction, with random sender gaps before it
	task automatic send_access(input logic [sacd_pkg::ADDR_BITS-1:0] addr, input logic act);
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		address <= addr;
		action  <= act;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_lookup(addr, act);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		lookup_result_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (pending_lookups.size() == 0) begin
				error_count++;
				if (error_count <= MAX_SHOWN)
					$display("unexpected result: hit=%0b line=%0d total=%0d",
						hit, line_index, cycle_total);
			end else begin
				exp_res = pending_lookups.pop_front();
				if (hit !== exp_res.hit || line_index !== exp_res.line ||
						cycle_total !== exp_res.total) begin
					error_count++;
					if (error_count <= MAX_SHOWN)
						$display({"mismatch: hit exp %0b got %0b, line exp %0d got %0d,",
							" total exp %0d got %0d"},
							exp_res.hit, hit, exp_res.line, line_index,
							exp_res.total, cycle_total);
				end
			end
		end
	end

	// Address extremes, stale zero tags after reset, read/write hit costs
	task automatic test_address_extremes();
		send_access(32'h0000_0000, sacd_pkg::ACT_READ);
		send_access(32'h0000_0000, sacd_pkg::ACT_READ);
		send_access(32'h0000_003F, sacd_pkg::ACT_WRITE);
		send_access(32'hFFFF_FFFF, sacd_pkg::ACT_WRITE);
		send_access(32'hFFFF_FFC0, sacd_pkg::ACT_READ);
		send_access(32'hFFFF_FFFF, sacd_pkg::ACT_WRITE);
	endtask

	// Fill one set, then force LFSR victims and probe what survived
	task automatic test_set_replacement();
		int unsigned t;
		for (t = 1; t <= sacd_pkg::WAYS; t++)
			send_access(make_addr(sacd_pkg::TAG_BITS'(t), 5, t),
				(t % 2) ? sacd_pkg::ACT_WRITE : sacd_pkg::ACT_READ);
		for (t = 1; t <= sacd_pkg::WAYS; t++)
			send_access(make_addr(sacd_pkg::TAG_BITS'(t), 5, 0), sacd_pkg::ACT_READ);
		for (t = sacd_pkg::WAYS + 1; t <= sacd_pkg::WAYS + 6; t++)
			send_access(make_addr(sacd_pkg::TAG_BITS'(t), 5, 63),
				(t % 2) ? sacd_pkg::ACT_WRITE : sacd_pkg::ACT_READ);
		for (t = 1; t <= sacd_pkg::WAYS + 2; t++)
			send_access(make_addr(sacd_pkg::TAG_BITS'(t), 5, 1), sacd_pkg::ACT_READ);
	endtask

	// Random traffic: mostly a small hot working set, some full-range addresses
	task automatic test_random_traffic(input int count, input int gap_pct);
		logic [sacd_pkg::TAG_BITS-1:0]  tag_base;
		logic [sacd_pkg::ADDR_BITS-1:0] addr;
		int                             n;
		int unsigned                    set_num;
		send_gap_pct = gap_pct;
		tag_base     = sacd_pkg::TAG_BITS'($urandom);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 80) begin
				set_num = ($urandom_range(99) < 10) ? sacd_pkg::NUM_SETS - 1
					: $urandom_range(0, 3);
				addr    = make_addr(
					sacd_pkg::TAG_BITS'(tag_base + $urandom_range(0, sacd_pkg::WAYS + 2)),
					set_num, $urandom_range(0, (1 << sacd_pkg::OFFSET_BITS) - 1));
			end else begin
				addr = $urandom;
			end
			send_access(addr, 1'($urandom_range(0, 1)));
		end
		stop_sending();
	endtask

	// Wait for outstanding results, then let the pipeline drain
	task automatic drain_results();
		int waited;
		waited = 0;
		while (pending_lookups.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			error_count++;
			if (error_count <= MAX_SHOWN)
				$display("%0d expected results never arrived", pending_lookups.size());
		end
	endtask

	initial begin
		start        = 1'b0;
		address      = '0;
		action       = sacd_pkg::ACT_READ;
		arst_n       = 1'b0;
		error_count  = 0;
		send_gap_pct = 0;
		victim_seq   = sacd_pkg::LFSR_SEED;
		cost_total   = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i]   = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_address_extremes();
		test_set_replacement();
		stop_sending();
		test_random_traffic(195, 35);
		test_random_traffic(195, 73);
		test_random_traffic(195, 0);
		drain_results();

		if (error_count == 0)
			$display("set_assoc_cache_tag_directory_top test passed");
		else
			$display("set_assoc_cache_tag_directory_top test failed");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("set_assoc_cache_tag_directory_top test failed");
		$finish;
	end

endmodule
